[sv/rrqs_pkg.sv]
// shared constants and types for the round-robin quantum scheduler
// no dependencies; used by round_robin_quantum_scheduler
package rrqs_pkg;

    localparam int MACHINES    = 8;
    localparam int QUEUE_DEPTH = 64;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MACH_W = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam int DCNT_W = $clog2(MACHINES + 1);

    localparam int OPC_W  = 3;
    localparam int JOB_W  = 8;
    localparam int MID_W  = 3;
    localparam int TICK_W = 16;
    localparam int QCNT_W = 7;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [OPC_W-1:0] {
        OP_ADD    = 3'd0,
        OP_TAKE   = 3'd1,
        OP_ASSIGN = 3'd2,
        OP_WORKED = 3'd3,
        OP_TICK   = 3'd4
    } t_opcode;

    // register index carried in paddr[2]
    localparam logic REG_QUANTUM = 1'b0;

endpackage

[sv/round_robin_quantum_scheduler.sv]
// round-robin scheduler with time quantum: sequencer, waiting fifo memory,
// per-machine tick counters and deferred list; depends on rrqs_pkg
//
// states from accept to result valid: exec, done for add, assigned, an unused
// code, take next on an empty queue and a worked event that counts nothing;
// exec, pop, done for take next; exec, cmp, done for a counted worked event;
// exec, drain, done for tick finished (one fifo write per cycle for each parked
// job, over the single write port). one item at a time: ready again once the
// result is in the output register, after any wait for the last one to leave.
// reset (synchronous, active low) empties fifo and deferred list, clears all
// tick counters and sets the quantum to 1.
module round_robin_quantum_scheduler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item in
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rrqs_pkg::OPC_W-1:0]   i_opcode,
    input  logic [rrqs_pkg::JOB_W-1:0]   i_job_id,
    input  logic [rrqs_pkg::MID_W-1:0]   i_machine_id,
    input  logic                         i_machine_busy,
    input  logic                         i_job_done,
    input  logic                         i_work_left,
    // result out
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_job_valid,
    output logic [rrqs_pkg::JOB_W-1:0]   o_job_out,
    output logic                         o_release_res,
    output logic                         o_pending,
    output logic [rrqs_pkg::QCNT_W-1:0]  o_queue_count,
    output logic                         o_overflow,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rrqs_pkg::APB_AW-1:0]  paddr,
    input  logic [rrqs_pkg::APB_DW-1:0]  pwdata,
    output logic [rrqs_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CMP,
        ST_POP,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state                              r_state;

    logic [rrqs_pkg::TICK_W-1:0]         r_quantum;

    // latched item
    rrqs_pkg::t_opcode                   r_op;
    logic [rrqs_pkg::JOB_W-1:0]          r_job;
    logic [rrqs_pkg::MACH_W-1:0]         r_mach;
    logic                                r_in_range;
    logic                                r_busy;
    logic                                r_done;
    logic                                r_left;

    // queue state
    logic [rrqs_pkg::JOB_W-1:0]          r_fifo_mem [rrqs_pkg::QUEUE_DEPTH];
    logic [rrqs_pkg::JOB_W-1:0]          r_rd_data;
    logic [rrqs_pkg::PTR_W-1:0]          r_head;
    logic [rrqs_pkg::PTR_W-1:0]          r_tail;
    logic [rrqs_pkg::CNT_W-1:0]          r_fifo_count;
    logic [rrqs_pkg::TICK_W-1:0]         r_ticks [rrqs_pkg::MACHINES];
    logic [rrqs_pkg::JOB_W-1:0]          r_deferred [rrqs_pkg::MACHINES];
    logic [rrqs_pkg::DCNT_W-1:0]         r_def_count;
    logic [rrqs_pkg::DCNT_W-1:0]         r_idx;

    // shared tick unit result
    logic [rrqs_pkg::TICK_W-1:0]         r_acc;
    logic [rrqs_pkg::TICK_W-1:0]         n_acc;
    logic [rrqs_pkg::TICK_W-1:0]         w_tick_cur;
    logic [rrqs_pkg::TICK_W-1:0]         w_eff_quantum;

    // working result
    logic                                r_job_valid;
    logic [rrqs_pkg::JOB_W-1:0]          r_job_out;
    logic                                r_release;
    logic                                r_ovf;

    // output register
    logic                                r_out_valid;
    logic                                r_o_job_valid;
    logic [rrqs_pkg::JOB_W-1:0]          r_o_job_out;
    logic                                r_o_release;
    logic                                r_o_pending;
    logic [rrqs_pkg::QCNT_W-1:0]         r_o_count;
    logic                                r_o_ovf;

    logic                                w_fifo_full;
    logic                                w_drain_more;
    logic                                w_mem_we;
    logic [rrqs_pkg::JOB_W-1:0]          w_mem_wd;
    logic                                w_def_we;
    logic                                w_cfg_we;
    logic [rrqs_pkg::PTR_W-1:0]          w_head_nxt;
    logic [rrqs_pkg::PTR_W-1:0]          w_tail_nxt;
    logic [rrqs_pkg::QCNT_W-1:0]         w_total;

    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite & pready & (paddr[2] == rrqs_pkg::REG_QUANTUM);
    assign prdata   = (paddr[2] == rrqs_pkg::REG_QUANTUM)
                    ? {{(rrqs_pkg::APB_DW - rrqs_pkg::TICK_W){1'b0}}, r_quantum}
                    : '0;

    assign o_ready = (r_state == ST_IDLE);

    assign w_fifo_full  = (r_fifo_count == rrqs_pkg::CNT_W'(rrqs_pkg::QUEUE_DEPTH));
    assign w_drain_more = (r_idx < r_def_count);

    assign w_head_nxt = (r_head == rrqs_pkg::PTR_W'(rrqs_pkg::QUEUE_DEPTH - 1))
                      ? '0 : r_head + rrqs_pkg::PTR_W'(1);
    assign w_tail_nxt = (r_tail == rrqs_pkg::PTR_W'(rrqs_pkg::QUEUE_DEPTH - 1))
                      ? '0 : r_tail + rrqs_pkg::PTR_W'(1);

    assign w_total = rrqs_pkg::QCNT_W'(r_fifo_count) + rrqs_pkg::QCNT_W'(r_def_count);

    // zero quantum behaves as one
    assign w_eff_quantum = (r_quantum == '0) ? rrqs_pkg::TICK_W'(1) : r_quantum;
    assign w_tick_cur    = r_ticks[r_mach];
    assign n_acc         = (w_tick_cur == '1) ? w_tick_cur
                                              : w_tick_cur + rrqs_pkg::TICK_W'(1);

    always_comb begin
        w_mem_we = 1'b0;
        w_mem_wd = r_job;
        if (r_state == ST_EXEC && r_op == rrqs_pkg::OP_ADD && !w_fifo_full) begin
            w_mem_we = 1'b1;
        end else if (r_state == ST_DRAIN && w_drain_more && !w_fifo_full) begin
            w_mem_we = 1'b1;
            w_mem_wd = r_deferred[r_idx[rrqs_pkg::MACH_W-1:0]];
        end
    end

    assign w_def_we = (r_state == ST_CMP) && (r_acc >= w_eff_quantum) && r_left
                    && (r_def_count < rrqs_pkg::DCNT_W'(rrqs_pkg::MACHINES));

    // waiting fifo storage, head entry always read into a register
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_fifo_mem[r_tail] <= w_mem_wd;
        end
        r_rd_data <= r_fifo_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (w_def_we) begin
            r_deferred[r_def_count[rrqs_pkg::MACH_W-1:0]] <= r_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_quantum    <= rrqs_pkg::TICK_W'(1);
            r_head       <= '0;
            r_tail       <= '0;
            r_fifo_count <= '0;
            r_def_count  <= '0;
            r_out_valid  <= 1'b0;
            for (int m = 0; m < rrqs_pkg::MACHINES; m++) begin
                r_ticks[m] <= '0;
            end
        end else begin
            if (w_cfg_we) begin
                r_quantum <= pwdata[rrqs_pkg::TICK_W-1:0];
            end
            // in the done state the output register is reloaded below instead
            if (r_out_valid && i_ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_op        <= rrqs_pkg::t_opcode'(i_opcode);
                        r_job       <= i_job_id;
                        r_mach      <= rrqs_pkg::MACH_W'(i_machine_id);
                        r_in_range  <= (32'(i_machine_id) < rrqs_pkg::MACHINES);
                        r_busy      <= i_machine_busy;
                        r_done      <= i_job_done;
                        r_left      <= i_work_left;
                        r_job_valid <= 1'b0;
                        r_job_out   <= '0;
                        r_release   <= 1'b0;
                        r_ovf       <= 1'b0;
                        r_idx       <= '0;
                        r_state     <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    unique case (r_op)
                        rrqs_pkg::OP_ADD: begin
                            if (w_fifo_full) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_tail       <= w_tail_nxt;
                                r_fifo_count <= r_fifo_count + rrqs_pkg::CNT_W'(1);
                            end
                            r_state <= ST_DONE;
                        end
                        rrqs_pkg::OP_TAKE: begin
                            r_state <= (r_fifo_count != '0) ? ST_POP : ST_DONE;
                        end
                        rrqs_pkg::OP_ASSIGN: begin
                            if (r_in_range) begin
                                r_ticks[r_mach] <= '0;
                            end
                            r_state <= ST_DONE;
                        end
                        rrqs_pkg::OP_WORKED: begin
                            if (r_in_range && r_busy && !r_done) begin
                                r_acc   <= n_acc;
                                r_state <= ST_CMP;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                        rrqs_pkg::OP_TICK: begin
                            r_state <= ST_DRAIN;
                        end
                        default: begin
                            r_state <= ST_DONE;
                        end
                    endcase
                end
                ST_CMP: begin
                    // quantum used up with work remaining: release and park, or flag overflow
                    if (r_acc >= w_eff_quantum && r_left) begin
                        r_release       <= 1'b1;
                        r_ticks[r_mach] <= '0;
                        if (w_def_we) begin
                            r_def_count <= r_def_count + rrqs_pkg::DCNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end else begin
                        r_ticks[r_mach] <= r_acc;
                    end
                    r_state <= ST_DONE;
                end
                ST_POP: begin
                    r_job_valid  <= 1'b1;
                    r_job_out    <= r_rd_data;
                    r_head       <= w_head_nxt;
                    r_fifo_count <= r_fifo_count - rrqs_pkg::CNT_W'(1);
                    r_state      <= ST_DONE;
                end
                ST_DRAIN: begin
                    // one parked item moved to the fifo tail per cycle, or dropped with overflow
                    if (w_drain_more) begin
                        if (w_fifo_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_tail       <= w_tail_nxt;
                            r_fifo_count <= r_fifo_count + rrqs_pkg::CNT_W'(1);
                        end
                        r_idx <= r_idx + rrqs_pkg::DCNT_W'(1);
                    end else begin
                        r_def_count <= '0;
                        r_state     <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid   <= 1'b1;
                        r_o_job_valid <= r_job_valid;
                        r_o_job_out   <= r_job_out;
                        r_o_release   <= r_release;
                        r_o_pending   <= (w_total != '0);
                        r_o_count     <= w_total;
                        r_o_ovf       <= r_ovf;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_job_valid   = r_o_job_valid;
    assign o_job_out     = r_o_job_out;
    assign o_release_res = r_o_release;
    assign o_pending     = r_o_pending;
    assign o_queue_count = r_o_count;
    assign o_overflow    = r_o_ovf;

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_count <= rrqs_pkg::CNT_W'(rrqs_pkg::QUEUE_DEPTH))
        else $error("waiting fifo count above depth");

    a_def_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_def_count <= rrqs_pkg::DCNT_W'(rrqs_pkg::MACHINES))
        else $error("deferred count above machine count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready while an item is in progress");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && !w_drain_more) |=> (r_def_count == '0))
        else $error("deferred list not emptied after tick finished");

endmodule

[tb/sv/tb_round_robin_quantum_scheduler.sv]
`timescale 1ns / 100ps
// self-checking testbench for round_robin_quantum_scheduler: directed, fifo limit,
// random, back-pressure and long-quantum tests against an in-bench model
// depends on rrqs_pkg and the scheduler rtl
module tb_round_robin_quantum_scheduler;

    typedef struct packed {
        logic                        job_valid;
        logic [rrqs_pkg::JOB_W-1:0]  job_out;
        logic                        release_res;
        logic                        pending;
        logic [rrqs_pkg::QCNT_W-1:0] queue_count;
        logic                        overflow;
    } t_sched_result;

    localparam logic [rrqs_pkg::APB_AW-1:0] QUANTUM_ADDR = {rrqs_pkg::REG_QUANTUM, 2'b00};

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_valid        = 1'b0;
    logic [rrqs_pkg::OPC_W-1:0]   i_opcode       = '0;
    logic [rrqs_pkg::JOB_W-1:0]   i_job_id       = '0;
    logic [rrqs_pkg::MID_W-1:0]   i_machine_id   = '0;
    logic                         i_machine_busy = 1'b0;
    logic                         i_job_done     = 1'b0;
    logic                         i_work_left    = 1'b0;
    logic                         i_ready        = 1'b0;
    logic                         psel           = 1'b0;
    logic                         penable        = 1'b0;
    logic                         pwrite         = 1'b0;
    logic [rrqs_pkg::APB_AW-1:0]  paddr          = '0;
    logic [rrqs_pkg::APB_DW-1:0]  pwdata         = '0;
    wire                          o_ready;
    wire                          o_valid;
    wire                          o_job_valid;
    wire  [rrqs_pkg::JOB_W-1:0]   o_job_out;
    wire                          o_release_res;
    wire                          o_pending;
    wire  [rrqs_pkg::QCNT_W-1:0]  o_queue_count;
    wire                          o_overflow;
    wire  [rrqs_pkg::APB_DW-1:0]  prdata;
    wire                          pready;

    round_robin_quantum_scheduler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_job_id       (i_job_id),
        .i_machine_id   (i_machine_id),
        .i_machine_busy (i_machine_busy),
        .i_job_done     (i_job_done),
        .i_work_left    (i_work_left),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_job_valid    (o_job_valid),
        .o_job_out      (o_job_out),
        .o_release_res  (o_release_res),
        .o_pending      (o_pending),
        .o_queue_count  (o_queue_count),
        .o_overflow     (o_overflow),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scheduler model state
    logic [rrqs_pkg::JOB_W-1:0]  wait_mem [rrqs_pkg::QUEUE_DEPTH];
    int unsigned                 wq_head, wq_tail, wq_count;
    logic [rrqs_pkg::TICK_W-1:0] ticks [rrqs_pkg::MACHINES];
    logic [rrqs_pkg::JOB_W-1:0]  parked [rrqs_pkg::MACHINES];
    int unsigned                 parked_count;
    logic [rrqs_pkg::TICK_W-1:0] quantum;

    t_sched_result sched_result_q[$];
    t_sched_result head_result;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int errors        = 0;
    int n_items       = 0;
    int n_results     = 0;
    int n_releases    = 0;
    int n_drops       = 0;
    int n_settings    = 0;

    function automatic logic [rrqs_pkg::JOB_W-1:0] rand_job();
        return rrqs_pkg::JOB_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [rrqs_pkg::MID_W-1:0] rand_mach();
        return rrqs_pkg::MID_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [rrqs_pkg::OPC_W-1:0] rand_op();
        return rrqs_pkg::OPC_W'($urandom_range(0, 7));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic bit wait_push(input logic [rrqs_pkg::JOB_W-1:0] job);
        if (wq_count >= rrqs_pkg::QUEUE_DEPTH) return 1'b0;
        wait_mem[wq_tail] = job;
        wq_tail = (wq_tail + 1 >= rrqs_pkg::QUEUE_DEPTH) ? 0 : wq_tail + 1;
        wq_count++;
        return 1'b1;
    endfunction

    function automatic t_sched_result sched_event(input logic [rrqs_pkg::OPC_W-1:0] op,
                                                  input logic [rrqs_pkg::JOB_W-1:0] job,
                                                  input logic [rrqs_pkg::MID_W-1:0] mach,
                                                  input logic busy, done, left);
        t_sched_result r;
        int unsigned   q_eff;
        r = '0;
        // a zero quantum behaves as one tick
        q_eff = (quantum == 0) ? 1 : quantum;
        case (op)
            rrqs_pkg::OP_ADD: begin
                if (!wait_push(job)) r.overflow = 1'b1;
            end
            rrqs_pkg::OP_TAKE: begin
                if (wq_count > 0) begin
                    r.job_valid = 1'b1;
                    r.job_out   = wait_mem[wq_head];
                    wq_head = (wq_head + 1 >= rrqs_pkg::QUEUE_DEPTH) ? 0 : wq_head + 1;
                    wq_count--;
                end
            end
            rrqs_pkg::OP_ASSIGN: begin
                if (mach < rrqs_pkg::MACHINES) ticks[mach] = '0;
            end
            rrqs_pkg::OP_WORKED: begin
                if (mach < rrqs_pkg::MACHINES && busy && !done) begin
                    if (ticks[mach] != '1) ticks[mach]++;
                    if (ticks[mach] >= q_eff && left) begin
                        r.release_res = 1'b1;
                        if (parked_count < rrqs_pkg::MACHINES) begin
                            parked[parked_count] = job;
                            parked_count++;
                        end else begin
                            r.overflow = 1'b1;
                        end
                        ticks[mach] = '0;
                    end
                end
            end
            rrqs_pkg::OP_TICK: begin
                for (int i = 0; i < parked_count; i++) begin
                    if (!wait_push(parked[i])) r.overflow = 1'b1;
                end
                parked_count = 0;
            end
            default: ;
        endcase
        r.pending     = (wq_count > 0 || parked_count > 0);
        r.queue_count = rrqs_pkg::QCNT_W'(wq_count + parked_count);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [rrqs_pkg::JOB_W-1:0] expv,
                               input logic [rrqs_pkg::JOB_W-1:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, expv, actv);
            errors++;
        end
    endtask

    // result side: checks each item taken and drives i_ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (sched_result_q.size() == 0) begin
                $display("%0t: result with nothing expected, queue_count %0d",
                         $time, o_queue_count);
                errors++;
            end else begin
                head_result = sched_result_q.pop_front();
                check_field("job_valid", rrqs_pkg::JOB_W'(head_result.job_valid),
                            rrqs_pkg::JOB_W'(o_job_valid));
                check_field("job_out", head_result.job_out, o_job_out);
                check_field("release_res", rrqs_pkg::JOB_W'(head_result.release_res),
                            rrqs_pkg::JOB_W'(o_release_res));
                check_field("pending", rrqs_pkg::JOB_W'(head_result.pending),
                            rrqs_pkg::JOB_W'(o_pending));
                check_field("queue_count", rrqs_pkg::JOB_W'(head_result.queue_count),
                            rrqs_pkg::JOB_W'(o_queue_count));
                check_field("overflow", rrqs_pkg::JOB_W'(head_result.overflow),
                            rrqs_pkg::JOB_W'(o_overflow));
            end
            n_results++;
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic [rrqs_pkg::OPC_W-1:0] op,
                             input logic [rrqs_pkg::JOB_W-1:0] job,
                             input logic [rrqs_pkg::MID_W-1:0] mach,
                             input logic busy, done, left);
        t_sched_result r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_job_id       <= job;
        i_machine_id   <= mach;
        i_machine_busy <= busy;
        i_job_done     <= done;
        i_work_left    <= left;
        do @(posedge i_clk); while (!o_ready);
        r = sched_event(op, job, mach, busy, done, left);
        sched_result_q.insert(sched_result_q.size(), r);
        n_items++;
        if (r.release_res) n_releases++;
        if (r.overflow) n_drops++;
    endtask

    // fields that the operation ignores still get random values
    task automatic send_simple(input logic [rrqs_pkg::OPC_W-1:0] op,
                               input logic [rrqs_pkg::JOB_W-1:0] job);
        send_item(op, job, rand_mach(), rand_bit(), rand_bit(), rand_bit());
    endtask

    task automatic wait_drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sched_result_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_quantum(input logic [rrqs_pkg::APB_DW-1:0] value);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= QUANTUM_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        quantum = value[rrqs_pkg::TICK_W-1:0];
        n_settings++;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[rrqs_pkg::TICK_W-1:0] !== value[rrqs_pkg::TICK_W-1:0]) begin
            $display("%0t: time_quantum readback expected %0h actual %0h",
                     $time, value[rrqs_pkg::TICK_W-1:0], prdata[rrqs_pkg::TICK_W-1:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_directed_events;
        send_simple(rrqs_pkg::OP_TAKE, 8'h5A);                   // empty queue
        send_simple(rrqs_pkg::OP_ADD, 8'h00);
        send_simple(rrqs_pkg::OP_ADD, 8'hFF);
        send_simple(rrqs_pkg::OP_ADD, 8'hA5);
        send_simple(rrqs_pkg::OP_TAKE, 8'h00);
        send_item(rrqs_pkg::OP_ASSIGN, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0);
        send_item(rrqs_pkg::OP_ASSIGN, 8'hFF, 3'd7, 1'b1, 1'b1, 1'b1);
        send_item(rrqs_pkg::OP_WORKED, 8'hFF, 3'd0, 1'b1, 1'b0, 1'b1);
        send_item(rrqs_pkg::OP_WORKED, 8'h11, 3'd7, 1'b0, 1'b0, 1'b1);  // idle machine
        send_item(rrqs_pkg::OP_WORKED, 8'h22, 3'd7, 1'b1, 1'b1, 1'b1);  // finished job
        // quantum reached but no work left: keeps counting
        send_item(rrqs_pkg::OP_WORKED, 8'h01, 3'd7, 1'b1, 1'b0, 1'b0);
        send_item(rrqs_pkg::OP_WORKED, 8'h01, 3'd7, 1'b1, 1'b0, 1'b0);
        send_item(rrqs_pkg::OP_WORKED, 8'h01, 3'd7, 1'b1, 1'b0, 1'b1);
        send_simple(rrqs_pkg::OP_TICK, 8'h33);
        send_simple(3'd5, 8'hC3);
        send_simple(3'd6, 8'h3C);
        send_simple(3'd7, 8'hFF);
        write_quantum(32'd0);
        send_item(rrqs_pkg::OP_ASSIGN, 8'h00, 3'd1, 1'b0, 1'b0, 1'b0);
        send_item(rrqs_pkg::OP_WORKED, 8'h44, 3'd1, 1'b1, 1'b0, 1'b1);
        // upper bus bits are not part of the register
        write_quantum({16'($urandom), 16'd3});
        send_item(rrqs_pkg::OP_ASSIGN, 8'h00, 3'd2, 1'b1, 1'b0, 1'b1);
        repeat (3) send_item(rrqs_pkg::OP_WORKED, 8'h55, 3'd2, 1'b1, 1'b0, 1'b1);
        send_simple(rrqs_pkg::OP_TICK, 8'h00);
    endtask

    task automatic test_fifo_limits;
        write_quantum(32'd1);
        send_simple(rrqs_pkg::OP_TICK, rand_job());
        while (wq_count < rrqs_pkg::QUEUE_DEPTH) send_simple(rrqs_pkg::OP_ADD, rand_job());
        repeat (2) send_simple(rrqs_pkg::OP_ADD, rand_job());
        // three free slots, eight parked jobs: five are dropped
        repeat (3) send_simple(rrqs_pkg::OP_TAKE, rand_job());
        for (int m = 0; m < rrqs_pkg::MACHINES; m++) begin
            send_item(rrqs_pkg::OP_WORKED, rand_job(), rrqs_pkg::MID_W'(m),
                      1'b1, 1'b0, 1'b1);
        end
        send_simple(rrqs_pkg::OP_TICK, rand_job());
        // full deferred list, then tick with a full fifo
        for (int m = 0; m <= rrqs_pkg::MACHINES; m++) begin
            send_item(rrqs_pkg::OP_WORKED, rand_job(),
                      rrqs_pkg::MID_W'(m % rrqs_pkg::MACHINES), 1'b1, 1'b0, 1'b1);
        end
        send_simple(rrqs_pkg::OP_TICK, rand_job());
        while (wq_count > 0) send_simple(rrqs_pkg::OP_TAKE, rand_job());
        send_simple(rrqs_pkg::OP_TAKE, rand_job());
    endtask

    task automatic test_random_traffic(input int n_events);
        int stop_at;
        int sel;
        stop_at = n_items + n_events;
        while (n_items < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                send_item(rand_op(), rand_job(), rand_mach(),
                          rand_bit(), rand_bit(), rand_bit());
            end else if (sel < 45) begin
                // keep the queue hovering around half full
                if ($urandom_range(0, rrqs_pkg::QUEUE_DEPTH) < wq_count) begin
                    send_simple(rrqs_pkg::OP_TAKE, rand_job());
                end else begin
                    repeat ($urandom_range(1, 3)) send_simple(rrqs_pkg::OP_ADD, rand_job());
                end
            end else if (sel < 55) begin
                send_item(rrqs_pkg::OP_ASSIGN, rand_job(), rand_mach(),
                          rand_bit(), rand_bit(), rand_bit());
            end else if (sel < 90) begin
                send_item(rrqs_pkg::OP_WORKED, rand_job(), rand_mach(),
                          $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0,
                          $urandom_range(0, 4) != 0);
            end else begin
                send_simple(rrqs_pkg::OP_TICK, rand_job());
            end
        end
    endtask

    task automatic test_backpressure;
        wait_drain();
        hold_request = 400;
        test_random_traffic(24);
        wait_drain();
    endtask

    task automatic test_long_quantum;
        write_quantum(32'd65535);
        send_item(rrqs_pkg::OP_ASSIGN, 8'h00, 3'd3, 1'b1, 1'b0, 1'b0);
        // far below the quantum: counts up but never releases
        repeat (12) send_item(rrqs_pkg::OP_WORKED, rand_job(), 3'd3, 1'b1, 1'b0, 1'b1);
        send_simple(rrqs_pkg::OP_TICK, rand_job());
    endtask

    initial begin
        wq_head      = 0;
        wq_tail      = 0;
        wq_count     = 0;
        parked_count = 0;
        quantum      = 16'd1;
        for (int m = 0; m < rrqs_pkg::MACHINES; m++) ticks[m] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 29;
        recv_idle_pct = 72;
        test_directed_events();
        test_fifo_limits();
        write_quantum(32'd2);
        test_random_traffic(450);

        send_idle_pct = 72;
        recv_idle_pct = 29;
        write_quantum(32'd3);
        test_random_traffic(440);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_quantum(32'd1);
        test_random_traffic(450);
        test_long_quantum();

        wait_drain();
        repeat (16) @(posedge i_clk);
        if (sched_result_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sched_result_q.size());
            errors++;
        end
        $display("events %0d, results %0d, preemptions %0d, dropped-job events %0d",
                 n_items, n_results, n_releases, n_drops);
        $display("quantum set %0d times from zero to 65535, under stalls and long hold-off",
                 n_settings);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: run timed out", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
